// ===== rtl/rteg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rteg_pkg
// Shared types and constants for the random recursive tree edge generator.
// ----------------------------------------------------------------------------
package rteg_pkg;

    localparam int unsigned MT_N = 624;
    localparam int unsigned MT_M = 397;
    localparam int unsigned IDX_W = 10;
    localparam logic [31:0] SEED_RESET = 32'd7734;
    localparam logic [31:0] INIT_MULT = 32'd1812433253;
    localparam logic [31:0] MATRIX_A = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C = 32'hEFC60000;
    localparam int unsigned VERTEX_W = 16;
    localparam int unsigned END_W = 17;

    // states of the twister engine
    typedef enum logic [3:0] {
        MT_INIT_WR,
        MT_INIT_MUL,
        MT_IDLE,
        MT_TW_RD0,
        MT_TW_RD1,
        MT_TW_RD2,
        MT_TW_CALC,
        MT_DRAW_RD,
        MT_DRAW_WAIT,
        MT_DRAW_OUT
    } mt_state_t;

    // states of the edge sequencer
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_REQ1,
        SQ_REQ2,
        SQ_DIV,
        SQ_OUT
    } sq_state_t;

    function automatic logic [31:0] mt_temper(input logic [31:0] y);
        logic [31:0] t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rteg_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rteg_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module rteg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== rtl/rteg_twister.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rteg_twister
// MT19937 engine around one state memory: seeding sweep, in-place twist
// sweep and tempered draws on request.
// ----------------------------------------------------------------------------
module rteg_twister (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed_data,
    input  wire logic        draw_req,
    output logic             draw_valid,
    output logic      [31:0] draw_data,
    output logic             busy
);
    import rteg_pkg::*;

    mt_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W:0]     pos_reg, pos_next;
    logic [31:0]        prev_reg, prev_next;
    logic [31:0]        seed_reg, seed_next;
    logic [31:0]        cur_reg, cur_next;
    logic [31:0]        nxt_reg, nxt_next;
    logic [31:0]        mix_reg, mix_next;

    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [31:0]        wdata;
    logic [31:0]        rdata;
    logic [31:0]        y;
    logic [31:0]        tw;
    logic [IDX_W-1:0]   idx_p1;
    logic [IDX_W-1:0]   idx_pm;
    logic [IDX_W-1:0]   idx_p2;

    rteg_ram #(.WIDTH(32), .DEPTH(MT_N)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MT_INIT_WR;
            idx_reg   <= '0;
            pos_reg   <= (IDX_W + 1)'(MT_N);
            seed_reg  <= SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            seed_reg  <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        mix_reg   <= mix_next;
    end

    always_comb
    begin
        idx_p1 = (idx_reg == IDX_W'(MT_N - 1)) ? '0 : idx_reg + 1'b1;
        idx_pm = (idx_reg >= IDX_W'(MT_N - MT_M)) ? idx_reg - IDX_W'(MT_N - MT_M)
                                                   : idx_reg + IDX_W'(MT_M);
        idx_p2 = (idx_p1 == IDX_W'(MT_N - 1)) ? '0 : idx_p1 + 1'b1;
        y  = {cur_reg[31], nxt_reg[30:0]};
        tw = rdata ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        seed_next  = seed_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        mix_next   = mix_reg;
        we         = 1'b0;
        addr       = idx_reg;
        wdata      = prev_reg;
        draw_valid = 1'b0;
        draw_data  = mt_temper(rdata);
        busy       = (state_reg == MT_INIT_WR) || (state_reg == MT_INIT_MUL);

        case (state_reg)
            MT_INIT_WR:
            begin
                we    = 1'b1;
                wdata = (idx_reg == '0) ? seed_reg : prev_reg;
                if (idx_reg == '0)
                begin
                    prev_next = seed_reg;
                end
                if (idx_reg == IDX_W'(MT_N - 1))
                begin
                    idx_next   = '0;
                    pos_next   = (IDX_W + 1)'(MT_N);
                    state_next = MT_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    mix_next   = wdata ^ (wdata >> 30);
                    state_next = MT_INIT_MUL;
                end
            end
            MT_INIT_MUL:
            begin
                // product held in a register before the next write
                prev_next  = mix_reg * INIT_MULT + 32'(idx_reg);
                state_next = MT_INIT_WR;
            end
            MT_IDLE:
            begin
                if (draw_req)
                begin
                    if (pos_reg >= (IDX_W + 1)'(MT_N))
                    begin
                        idx_next   = '0;
                        state_next = MT_TW_RD0;
                    end
                    else
                    begin
                        state_next = MT_DRAW_RD;
                    end
                end
            end
            MT_TW_RD0:
            begin
                addr       = '0;
                state_next = MT_TW_RD1;
            end
            MT_TW_RD1:
            begin
                addr = idx_p1;
                if (idx_reg == '0)
                begin
                    cur_next = rdata;
                end
                state_next = MT_TW_RD2;
            end
            MT_TW_RD2:
            begin
                // the last step sees word 0 as already rewritten
                addr       = idx_pm;
                nxt_next   = rdata;
                state_next = MT_TW_CALC;
            end
            MT_TW_CALC:
            begin
                // word i+M was rewritten already when it wraps below i
                we    = 1'b1;
                addr  = idx_reg;
                wdata = tw;
                cur_next = nxt_reg;
                if (idx_reg == IDX_W'(MT_N - 1))
                begin
                    idx_next   = '0;
                    pos_next   = '0;
                    state_next = MT_DRAW_RD;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = MT_TW_RD1;
                end
                if (idx_p2 == '0)
                begin
                    state_next = (idx_reg == IDX_W'(MT_N - 1)) ? MT_DRAW_RD : MT_TW_RD1;
                end
            end
            MT_DRAW_RD:
            begin
                addr       = pos_reg[IDX_W-1:0];
                state_next = MT_DRAW_WAIT;
            end
            MT_DRAW_WAIT:
            begin
                addr       = pos_reg[IDX_W-1:0];
                state_next = MT_DRAW_OUT;
            end
            MT_DRAW_OUT:
            begin
                draw_valid = 1'b1;
                pos_next   = pos_reg + 1'b1;
                state_next = MT_IDLE;
            end
            default:
            begin
                state_next = MT_IDLE;
            end
        endcase

        if (seed_we)
        begin
            seed_next  = seed_data;
            idx_next   = '0;
            state_next = MT_INIT_WR;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rteg_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rteg_divider
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module rteg_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic      [15:0] remainder
);
    import rteg_pkg::*;

    logic        run_reg, run_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [16:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done      = 1'b0;
        remainder = rem_reg[15:0];
        trial     = {rem_reg[15:0], num_reg[31]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            num_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[30:0], 1'b0};
            rem_next = (trial >= {1'b0, den_reg}) ? trial - {1'b0, den_reg} : trial;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd31)
            begin
                run_next = 1'b0;
            end
        end
        else if (cnt_reg == 6'd32)
        begin
            done     = 1'b1;
            cnt_next = '0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/random_tree_edge_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// random_tree_edge_generator
// Emits one edge of a random recursive tree per input vertex index.
// ----------------------------------------------------------------------------
// per word: two draws from the twister, then the bit-serial remainder
//   unit; every 312th word adds a twist sweep
// throughput: one word at a time, taken only while the sequencer is idle
// reset: state memory is seeded from 7734 in a seeding sweep, no word taken
module random_tree_edge_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] new_vertex,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [16:0] first_end,
    output logic      [16:0] second_end
);
    import rteg_pkg::*;

    sq_state_t   state_reg, state_next;
    logic [15:0] j_reg, j_next;
    logic [31:0] r1_reg, r1_next;
    logic        ovalid_reg, ovalid_next;
    logic [16:0] first_reg, first_next;
    logic [16:0] second_reg, second_next;
    logic        draw_req;
    logic        draw_valid;
    logic [31:0] draw_data;
    logic        busy;
    logic        div_start;
    logic        div_done;
    logic [15:0] rem;
    logic        order_bit_reg, order_bit_next;
    logic [16:0] jp1;
    logic [16:0] bp1;

    rteg_twister u_twister (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (cfg_we),
        .seed_data  (cfg_wdata),
        .draw_req   (draw_req),
        .draw_valid (draw_valid),
        .draw_data  (draw_data),
        .busy       (busy)
    );

    rteg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r1_reg),
        .divisor   (j_reg),
        .done      (div_done),
        .remainder (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SQ_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        r1_reg        <= r1_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        order_bit_reg <= order_bit_next;
    end

    assign in_ready   = (state_reg == SQ_IDLE) && !busy;
    assign out_valid  = ovalid_reg;
    assign first_end  = first_reg;
    assign second_end = second_reg;

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        r1_next        = r1_reg;
        ovalid_next    = ovalid_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        order_bit_next = order_bit_reg;
        draw_req       = 1'b0;
        div_start      = 1'b0;
        jp1            = {1'b0, j_reg} + 17'd1;
        bp1            = (j_reg == '0) ? 17'd1 : {1'b0, rem} + 17'd1;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            SQ_IDLE:
            begin
                if (in_valid && !busy)
                begin
                    j_next     = new_vertex;
                    draw_req   = 1'b1;
                    state_next = SQ_REQ1;
                end
            end
            SQ_REQ1:
            begin
                if (draw_valid)
                begin
                    r1_next    = draw_data;
                    state_next = SQ_REQ2;
                end
            end
            SQ_REQ2:
            begin
                // second draw is asked for once the engine is back in idle
                draw_req = !draw_valid;
                if (draw_valid)
                begin
                    order_bit_next = draw_data[0];
                    div_start      = 1'b1;
                    state_next     = SQ_DIV;
                end
            end
            SQ_DIV:
            begin
                if (div_done)
                begin
                    state_next = SQ_OUT;
                end
            end
            SQ_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    first_next  = order_bit_reg ? jp1 : bp1;
                    second_next = order_bit_reg ? bp1 : jp1;
                    state_next  = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_end))
        else $error("result word changed while stalled");
    a_one_endpoint_jp1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (first_end == 17'd1 && second_end == 17'd1) ||
            (first_end != second_end))
        else $error("edge endpoints equal for nonzero vertex");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("word taken while state memory is being seeded");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_random_tree_edge_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_tree_edge_generator
// Self-checking bench: a behavioural twister model predicts each edge, and the
// edges that come out are compared in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_random_tree_edge_generator;

    import rteg_pkg::*;

    typedef struct packed {
        logic [END_W-1:0] first_e;
        logic [END_W-1:0] second_e;
    } edge_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [31:0]       cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic [15:0]       new_vertex;
    logic              out_valid;
    logic              out_ready;
    logic [16:0]       first_end;
    logic [16:0]       second_end;

    logic [31:0]       mt_words [MT_N];
    int unsigned       mt_pos;
    edge_t             edge_q[$];
    int unsigned       err_count;
    longint unsigned   cycle_count;
    bit                calm;
    int unsigned       stall_left;

    localparam longint unsigned CYCLE_LIMIT = 64'd1200000;

    random_tree_edge_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .new_vertex (new_vertex),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .first_end  (first_end),
        .second_end (second_end)
    );

    always #5 clk = ~clk;

    // ---------------- twister model ----------------
    function automatic void seed_twister(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int i = 1; i < MT_N; i++)
        begin
            p = mt_words[i-1];
            p = p ^ (p >> 30);
            mt_words[i] = p * INIT_MULT + 32'(i);
        end
        mt_pos = MT_N;
    endfunction

    function automatic logic [31:0] next_draw();
        logic [31:0] y;
        logic [31:0] v;
        if (mt_pos >= MT_N)
        begin
            for (int i = 0; i < MT_N; i++)
            begin
                y = (mt_words[i] & 32'h80000000) | (mt_words[(i+1)%MT_N] & 32'h7FFFFFFF);
                v = mt_words[(i+MT_M)%MT_N] ^ (y >> 1);
                if (y[0])
                    v = v ^ MATRIX_A;
                mt_words[i] = v;
            end
            mt_pos = 0;
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic edge_t attach_vertex(input logic [15:0] j);
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] b;
        edge_t e;
        r1 = next_draw();
        r2 = next_draw();
        b = (j != 0) ? r1 % {16'd0, j} : 32'd0;
        if (r2[0])
        begin
            e.first_e  = {1'b0, j} + 17'd1;
            e.second_e = b[16:0] + 17'd1;
        end
        else
        begin
            e.first_e  = b[16:0] + 17'd1;
            e.second_e = {1'b0, j} + 17'd1;
        end
        return e;
    endfunction

    // ---------------- driving ----------------
    task automatic send_vertex(input logic [15:0] j);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        new_vertex <= j;
        edge_q.push_back(attach_vertex(j));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_edges();
        in_valid <= 1'b0;
        while (edge_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        drain_edges();
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_twister(s);
    endtask

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    // ---------------- checking ----------------
    always @(posedge clk)
    begin
        edge_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (edge_q.size() == 0)
            begin
                report_mismatch("unexpected edge", first_end, 17'd0);
            end
            else
            begin
                e = edge_q.pop_front();
                if (first_end != e.first_e)
                    report_mismatch("first_end", first_end, e.first_e);
                if (second_end != e.second_e)
                    report_mismatch("second_end", second_end, e.second_e);
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (calm)
        begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_random_tree_edge_generator: done, errors");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        send_vertex(16'd0);
        send_vertex(16'd1);
        send_vertex(16'd2);
        send_vertex(16'd3);
        send_vertex(16'hFFFF);
        send_vertex(16'hFFFE);
        send_vertex(16'h8000);
        send_vertex(16'h7FFF);
        send_vertex(16'h5555);
        send_vertex(16'hAAAA);
        send_vertex(16'd0);
        send_vertex(16'd1);
    endtask

    task automatic test_tree_walk(input int n);
        int j;
        j = 1;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 3))
                0: send_vertex(16'($urandom));
                1: send_vertex(16'($urandom_range(0, 3)));
                default:
                begin
                    send_vertex(16'(j));
                    j = (j >= 65535) ? 1 : j + 1;
                end
            endcase
        end
    endtask

    task automatic test_seeds();
        write_seed(32'd0);
        test_tree_walk(100);
        write_seed(32'hFFFFFFFF);
        test_tree_walk(100);
        write_seed($urandom);
        test_tree_walk(100);
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 32'd0;
        in_valid   = 1'b0;
        new_vertex = 16'd0;
        out_ready  = 1'b0;
        stall_left = 0;
        err_count  = 0;
        cycle_count = 0;
        calm       = 1'b0;
        seed_twister(SEED_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_tree_walk(400);
        test_seeds();
        write_seed(SEED_RESET);
        test_tree_walk(300);
        calm = 1'b1;
        test_tree_walk(150);
        drain_edges();
        if (err_count == 0)
            $display("tb_random_tree_edge_generator: done, clean");
        else
            $display("tb_random_tree_edge_generator: done, errors");
        $finish;
    end

endmodule

// ===== random_tree_edge_generator.f =====
rtl/rteg_pkg.sv
rtl/rteg_ram.sv
rtl/rteg_twister.sv
rtl/rteg_divider.sv
rtl/random_tree_edge_generator.sv
dv/tb_random_tree_edge_generator.sv
